[hdl/bslpm_pkg.sv]
// Shared types and constants for the button short/long press mode controller.
// No dependencies.
package bslpm_pkg;

  localparam int unsigned RuleW = 4;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_CONFIRM = 2'd1,
    PH_HOLD    = 2'd2,
    PH_WAIT    = 2'd3
  } phase_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLANKING = 2'd0,
    CFG_POLL     = 2'd1,
    CFG_LONG     = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_idx_t;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_RULE  = 2'd1;
  localparam logic [1:0] ACT_ENTER = 2'd2;
  localparam logic [1:0] ACT_LEAVE = 2'd3;

  localparam logic [15:0] BlankingReset = 16'd300;
  localparam logic [7:0]  PollReset     = 8'd50;
  localparam logic [15:0] LongReset     = 16'd5000;

  typedef struct packed {
    logic             mode;
    logic [RuleW-1:0] rule;
    logic [1:0]       action;
  } res_t;

endpackage

[hdl/button_short_long_press_mode_ctrl_core.sv]
// Button short/long press mode controller, top level.
// Depends on bslpm_pkg.
//
// Usage: one input word per millisecond tick carries button_level (active low).
// Each accepted word yields exactly one result word: mode, rule and action.
// Input channel: in_valid/in_stall; a word is taken when in_valid && !in_stall.
// Output channel: out_valid/out_stall; a word leaves when out_valid && !out_stall.
// Results are registered in the output register, or the skid one if it is stalled.
// Throughput: one word per cycle while in_stall is low; the press state
// update is one pass of compare and counter logic between the state registers.
// Stall: an output register plus a one-word skid register decouple the sides;
// in_stall rises only when both hold words, i.e. it is a registered signal.
// Reset (rst, synchronous): state returns to idle, run mode, rule 0, config
// registers to 300/50/5000 ms, and both output stages are emptied.
// Config: cfg_we writes cfg_data into register cfg_index (0 blanking window,
// 1 poll interval, 2 long hold time); write only while no word is in flight.
module button_short_long_press_mode_ctrl_core #(
  parameter int RULE_COUNT = 3
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bslpm_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [bslpm_pkg::CfgW-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            button_level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            mode,
  output logic [bslpm_pkg::RuleW-1:0]     rule,
  output logic [1:0]                      action
);
  import bslpm_pkg::*;

  localparam logic [RuleW-1:0] RuleLast = RuleW'(RULE_COUNT - 1);

  logic [15:0] blanking_window;
  logic [7:0]  poll_interval;
  logic [15:0] long_hold_time;

  logic             last_level;
  phase_t           phase, phase_next;
  logic [7:0]       poll_count, poll_count_next;
  logic [15:0]      hold_time, hold_time_next;
  logic [15:0]      since_press, since_press_next;
  logic             mode_bit, mode_bit_next;
  logic [RuleW-1:0] rule_index, rule_index_next;
  logic [1:0]       act;

  logic        accept, drain;
  logic        fall, due, long_hit, short_hit;
  logic [8:0]  poll_inc;
  logic [15:0] since_inc, hold_inc;
  logic        skid_valid;
  res_t        out_res, skid_res, new_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      blanking_window <= BlankingReset;
      poll_interval   <= PollReset;
      long_hold_time  <= LongReset;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BLANKING: blanking_window <= cfg_data;
        CFG_POLL:     poll_interval   <= cfg_data[7:0];
        CFG_LONG:     long_hold_time  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept    = in_valid && !skid_valid;
  assign drain     = out_valid && !out_stall;
  assign in_stall  = skid_valid;
  assign fall      = last_level && !button_level;
  assign since_inc = (since_press == 16'hFFFF) ? since_press : since_press + 16'd1;
  assign hold_inc  = (hold_time == 16'hFFFF) ? hold_time : hold_time + 16'd1;
  assign poll_inc  = {1'b0, poll_count} + 9'd1;
  assign due       = poll_inc >= {1'b0, poll_interval};

  // next state: phase and press decisions
  always_comb begin
    phase_next     = phase;
    hold_time_next = hold_time;
    long_hit       = 1'b0;
    short_hit      = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (fall && since_inc >= blanking_window) phase_next = PH_CONFIRM;
      end
      PH_CONFIRM: begin
        if (due) begin
          if (!button_level) begin
            hold_time_next = '0;
            if (long_hold_time == 16'd0) long_hit = 1'b1;
            else phase_next = PH_HOLD;
          end else begin
            phase_next = PH_IDLE;
          end
        end
      end
      PH_HOLD: begin
        hold_time_next = hold_inc;
        if (due) begin
          if (button_level) short_hit = 1'b1;
          else if (hold_inc >= long_hold_time) long_hit = 1'b1;
        end
      end
      PH_WAIT: begin
        if (due && button_level) phase_next = PH_IDLE;
      end
      default: phase_next = PH_IDLE;
    endcase
    if (long_hit) phase_next = PH_WAIT;
    if (short_hit) phase_next = PH_IDLE;
  end

  // outputs of a step: counters, mode, rule, action
  always_comb begin
    since_press_next = since_inc;
    mode_bit_next    = mode_bit;
    rule_index_next  = rule_index;
    act              = ACT_NONE;
    if (phase == PH_IDLE) begin
      poll_count_next = (phase_next == PH_CONFIRM) ? 8'd0 : poll_count;
    end else begin
      poll_count_next = due ? 8'd0 : poll_inc[7:0];
    end
    if (long_hit) begin
      since_press_next = '0;
      mode_bit_next    = !mode_bit;
      act              = mode_bit ? ACT_LEAVE : ACT_ENTER;
    end else if (short_hit) begin
      since_press_next = '0;
      if (!mode_bit) begin
        rule_index_next = (rule_index == RuleLast) ? '0 : rule_index + 1'b1;
        act             = ACT_RULE;
      end else begin
        mode_bit_next = 1'b0;
        act           = ACT_LEAVE;
      end
    end
  end

  assign new_res = '{mode: mode_bit_next, rule: rule_index_next, action: act};

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level  <= 1'b1;
      phase       <= PH_IDLE;
      poll_count  <= '0;
      hold_time   <= '0;
      since_press <= 16'hFFFF;
      mode_bit    <= 1'b0;
      rule_index  <= '0;
    end else if (accept) begin
      last_level  <= button_level;
      phase       <= phase_next;
      poll_count  <= poll_count_next;
      hold_time   <= hold_time_next;
      since_press <= since_press_next;
      mode_bit    <= mode_bit_next;
      rule_index  <= rule_index_next;
    end
  end

  // output register with one-word skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (drain && skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!out_valid || drain) begin
        out_valid <= accept;
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (drain && skid_valid) begin
      out_res <= skid_res;
    end else if ((!out_valid || drain) && accept) begin
      out_res <= new_res;
    end else if (accept) begin
      skid_res <= new_res;
    end
  end

  assign mode   = out_res.mode;
  assign rule   = out_res.rule;
  assign action = out_res.action;

endmodule

[hdl/bslpm_chk.sv]
// Port-level checker for the button short/long press mode controller.
// Depends on bslpm_pkg; bound to button_short_long_press_mode_ctrl_core.
module bslpm_chk #(
  parameter int RULE_COUNT = 3
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        mode,
  input logic [bslpm_pkg::RuleW-1:0] rule,
  input logic [1:0]                  action
);
  import bslpm_pkg::*;

  localparam logic [RuleW-1:0] RuleLast = RuleW'(RULE_COUNT - 1);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mode) && $stable(rule)
      && $stable(action))
    else $error("stalled output word changed");

  a_rule: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rule <= RuleLast)
    else $error("rule index out of range");

  a_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == ACT_RULE || action == ACT_LEAVE) |-> !mode)
    else $error("mode not run after rule advance or leaving storage");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_ENTER |-> mode)
    else $error("mode not storage after entering storage");

  a_skid: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && $past(out_valid))
    else $error("input stalled with empty output register");

endmodule

bind button_short_long_press_mode_ctrl_core bslpm_chk #(.RULE_COUNT(RULE_COUNT)) u_bslpm_chk (
  .clk(clk),
  .rst(rst),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .mode(mode),
  .rule(rule),
  .action(action)
);
